// ===== design/sms_pkg.sv =====
`default_nettype none

package sms_pkg;

  // Default geometry and element width
  localparam int ROWS_DEF       = 16;
  localparam int COLS_DEF       = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channels
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 32;
  localparam int EXT_W   = 64;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

endpackage

`default_nettype wire

// ===== design/sms_in_if.sv =====
`default_nettype none

interface sms_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [sms_pkg::IDX_W-1:0]         load_row;
  logic [sms_pkg::IDX_W-1:0]         load_col;
  logic signed [sms_pkg::VAL_W-1:0]  element_value;
  logic signed [sms_pkg::VAL_W-1:0]  search_key;

  modport source (
    output valid, opcode, load_row, load_col, element_value, search_key,
    input  ready
  );

  modport sink (
    input  valid, opcode, load_row, load_col, element_value, search_key,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/sms_out_if.sv =====
`default_nettype none

interface sms_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [sms_pkg::IDX_W-1:0] found_row;
  logic [sms_pkg::IDX_W-1:0] found_col;

  modport source (
    output valid, found, found_row, found_col,
    input  ready
  );

  modport sink (
    input  valid, found, found_row, found_col,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/sms_mem.sv =====
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data.
module sms_mem #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds when no read is issued; the walker relies on that
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/sms_walker.sv =====
`default_nettype none

// Staircase walk controller: one element compared per cycle, next read
// address picked from the compare of the element that just came back.
module sms_walker #(
  parameter int ROWS       = sms_pkg::ROWS_DEF,
  parameter int COLS       = sms_pkg::COLS_DEF,
  parameter int DATA_WIDTH = sms_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  sms_in_if.sink                            in_i,
  sms_out_if.source                         out_o,
  input  wire logic signed [DATA_WIDTH-1:0] key_i,
  input  wire logic        [DATA_WIDTH-1:0] rdata_i,
  output logic                              rd_en_o,
  output logic [((ROWS > 1) ? $clog2(ROWS) : 1) + ((COLS > 1) ? $clog2(COLS) : 1) - 1:0]
                                            rd_addr_o
);

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int POS_W = sms_pkg::IDX_W;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                        state_q, state_d;
  logic [RW-1:0]                 row_q, row_d;
  logic [CW-1:0]                 col_q, col_d;
  logic signed [DATA_WIDTH-1:0]  key_q;
  logic                          out_valid_q;
  logic                          found_q;
  logic [POS_W-1:0]              found_row_q, found_col_q;

  logic                          accept;
  logic                          start;
  logic                          slot_free;
  logic                          fin;
  logic                          hit;
  logic signed [DATA_WIDTH-1:0]  elem;
  logic                          is_eq;
  logic                          is_gt;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign start      = accept && (in_i.opcode == sms_pkg::OP_SEARCH);
  assign slot_free  = !out_valid_q || out_o.ready;

  assign elem  = signed'(rdata_i);
  assign is_eq = (elem == key_q);
  assign is_gt = (elem > key_q);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    rd_en_o = 1'b0;
    fin     = 1'b0;
    hit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          row_d   = '0;
          col_d   = CW'(COLS - 1);
          rd_en_o = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (is_eq) begin
          fin = 1'b1;
          hit = 1'b1;
        end else if (is_gt) begin
          if (col_q == '0) begin
            fin = 1'b1;
          end else begin
            col_d   = col_q - CW'(1);
            rd_en_o = 1'b1;
          end
        end else begin
          if (row_q == RW'(ROWS - 1)) begin
            fin = 1'b1;
          end else begin
            row_d   = row_q + RW'(1);
            rd_en_o = 1'b1;
          end
        end
        // Output slot busy: stay put, read data and key stay stable
        if (fin && slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = {row_d, col_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      found_row_q <= '0;
      found_col_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (start) begin
        key_q <= key_i;
      end
      if (fin && slot_free) begin
        out_valid_q <= 1'b1;
        found_q     <= hit;
        found_row_q <= hit ? POS_W'(row_q) : '0;
        found_col_q <= hit ? POS_W'(col_q) : '0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.found     = found_q;
  assign out_o.found_row = found_row_q;
  assign out_o.found_col = found_col_q;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (row_q <= RW'(ROWS - 1)) && (col_q <= CW'(COLS - 1)))
    else $error("walk position outside matrix");

  a_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && $past(state_q == ST_WALK) |->
      (row_q >= $past(row_q)) && (col_q <= $past(col_q)))
    else $error("walk moved up or right");

  a_start_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_WALK) && (row_q == '0) && (col_q == CW'(COLS - 1)))
    else $error("search did not start at top-right corner");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> (found_row_q == '0) && (found_col_q == '0))
    else $error("miss result carries nonzero position");
`endif

endmodule

`default_nettype wire

// ===== design/sorted_matrix_staircase_search.sv =====
`default_nettype none

// Channel  Dir  Payload                                               Beat when
// in_i     in   opcode, load_row, load_col, element_value, search_key valid && ready
// out_o    out  found, found_row, found_col                           valid && ready
//
// A load writes the element RAM at the accept edge.
// A search: the accept cycle issues the corner read, then one visited element
// is compared per cycle, set by the one RAM read port.
// in_i.ready is high only between items; a finished result waits in the
// output register, and a walk that ends while it is full holds until taken.
// Reset clears control state only; the element RAM is not cleared.
module sorted_matrix_staircase_search #(
  parameter int ROWS       = sms_pkg::ROWS_DEF,
  parameter int COLS       = sms_pkg::COLS_DEF,
  parameter int DATA_WIDTH = sms_pkg::DATA_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sms_in_if.sink    in_i,
  sms_out_if.source out_o
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW = RW + CW;

  logic                          load_we;
  logic [AW-1:0]                 load_addr;
  logic signed [sms_pkg::EXT_W-1:0] val_ext;
  logic signed [sms_pkg::EXT_W-1:0] key_ext;
  logic [DATA_WIDTH-1:0]         load_data;
  logic signed [DATA_WIDTH-1:0]  key_red;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [DATA_WIDTH-1:0]         rdata;

  // Out-of-range loads are dropped
  assign load_we = in_i.valid && in_i.ready
                && (in_i.opcode == sms_pkg::OP_LOAD)
                && (32'(in_i.load_row) < ROWS)
                && (32'(in_i.load_col) < COLS);
  assign load_addr = {RW'(in_i.load_row), CW'(in_i.load_col)};

  // Sign-extend, then wrap to the element width
  assign val_ext   = sms_pkg::EXT_W'(in_i.element_value);
  assign key_ext   = sms_pkg::EXT_W'(in_i.search_key);
  assign load_data = val_ext[DATA_WIDTH-1:0];
  assign key_red   = signed'(key_ext[DATA_WIDTH-1:0]);

  sms_mem #(
    .AW (AW),
    .DW (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr),
    .wdata_i (load_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  sms_walker #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .key_i     (key_red),
    .rdata_i   (rdata),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

endmodule

`default_nettype wire
